// File: rtl/core/ultrasonic_echo_ranger_macros.svh
// Assertion helpers for the echo ranger RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("echo ranger check failed");

// Next-cycle implication, disabled while reset is low
`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("echo ranger check failed");

`else

`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/uer_pkg.sv
package uer_pkg;

    // Configuration register widths and reset values
    localparam int CFG_PERIOD_W  = 20;
    localparam int CFG_TIMEOUT_W = 16;
    localparam int CFG_TRIGW_W   = 8;
    localparam int CFG_DATA_W    = 20;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_PERIOD_W-1:0]  PERIOD_RESET  = 20'd200000;
    localparam logic [CFG_TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;
    localparam logic [CFG_TRIGW_W-1:0]   TRIGW_RESET   = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_TIMEOUT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_WIDTH  = 2'd2;

    // Trigger sequencing
    localparam int                   PULSE_W    = 8;
    localparam logic [PULSE_W-1:0]   LEAD_TICKS = 8'd2;

    // Echo width and distance: distance_cm = floor(width * 17 / 1000)
    localparam int                     ECHO_W      = 16;
    localparam int                     DIST_W      = 11;
    localparam int                     DIST_REM_W  = 10;
    localparam logic [DIST_REM_W:0]    DIST_STEP   = 11'd17;
    localparam logic [DIST_REM_W:0]    DIST_DIV    = 11'd1000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_HIGH,
        PH_WAIT
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_OK,
        ST_FAIL
    } t_status;

endpackage

// File: rtl/core/ultrasonic_echo_ranger.sv
// Ultrasonic echo-pulse ranger.
//
// Input channel: one beat per microsecond tick, carrying the sampled echo
// pin level. Output channel: exactly one beat per input beat, carrying the
// trigger drive level for that tick, a status code (none, distance ready,
// failed) and the distance in cm, which is nonzero only with distance ready.
// Configuration channel: index and data, always ready; write it only while
// no input beat is outstanding.
//
// Output valid is registered and rises in the cycle after input acceptance.
// Throughput is one beat per cycle unless the receiver stalls: the phase
// sequencer, the saturating timers and the running quotient/remainder pair
// for floor(width * 17 / 1000) all advance in one registered step per tick.
// The output register holds a beat while the receiver stalls; a new input
// beat is taken in the same cycle the held beat leaves, so ready drops only
// while the output register is full and not being drained.
// Reset (synchronous, active low) returns the sequencer to idle, clears all
// timers and loads the configuration defaults 200000, 30000 and 10 ticks;
// the first trigger starts once the period has elapsed.
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int PERIOD_BITS = 20,
    parameter int WAIT_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_echo_level,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_trig_level,
    output logic [1:0]             o_status,
    output logic [DIST_W-1:0]      o_distance_cm,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PCMP_W = (PERIOD_BITS > CFG_PERIOD_W) ? PERIOD_BITS : CFG_PERIOD_W;
    localparam int WCMP_W = (WAIT_BITS > CFG_TIMEOUT_W) ? WAIT_BITS : CFG_TIMEOUT_W;

    // Configuration registers
    logic [CFG_PERIOD_W-1:0]  r_trigger_period_us;
    logic [CFG_TIMEOUT_W-1:0] r_echo_timeout_us;
    logic [CFG_TRIGW_W-1:0]   r_trigger_width_us;

    // Sequencer state
    t_phase                   r_phase, n_phase;
    logic [PERIOD_BITS-1:0]   r_period_timer, n_period_timer;
    logic [PULSE_W-1:0]       r_pulse_timer, n_pulse_timer;
    logic [WAIT_BITS-1:0]     r_wait_timer, n_wait_timer;
    logic [ECHO_W-1:0]        r_echo_width, n_echo_width;
    logic [DIST_REM_W-1:0]    r_rem, n_rem;
    logic [DIST_W-1:0]        r_dist, n_dist;
    logic                     r_echo_started, n_echo_started;
    logic                     r_last_echo;

    // Output register
    logic                     r_out_valid;
    logic                     r_out_trig, n_out_trig;
    t_status                  r_out_status, n_out_status;
    logic [DIST_W-1:0]        r_out_dist, n_out_dist;

    logic                     in_fire;
    logic                     rising;
    logic                     falling;
    logic                     period_done;
    logic [PULSE_W-1:0]       pulse_inc;
    logic [WAIT_BITS-1:0]     wait_inc;
    logic                     wait_expired;
    logic [ECHO_W-1:0]        width_inc;
    logic [DIST_REM_W:0]      rem_add;
    logic [DIST_REM_W-1:0]    rem_inc;
    logic [DIST_W-1:0]        dist_inc;
    logic                     echo_done;
    logic                     echo_ok;

    // Handshake: take a beat whenever the output slot is free or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_period_us <= PERIOD_RESET;
            r_echo_timeout_us   <= TIMEOUT_RESET;
            r_trigger_width_us  <= TRIGW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_PERIOD: r_trigger_period_us <= i_cfg_data[CFG_PERIOD_W-1:0];
                CFG_ECHO_TIMEOUT:   r_echo_timeout_us   <= i_cfg_data[CFG_TIMEOUT_W-1:0];
                CFG_TRIGGER_WIDTH:  r_trigger_width_us  <= i_cfg_data[CFG_TRIGW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Edge detection against the previous tick
    assign rising  = i_echo_level && !r_last_echo;
    assign falling = !i_echo_level && r_last_echo;

    // Period elapsed, including the saturated case
    assign period_done = (PCMP_W'(r_period_timer) >= PCMP_W'(r_trigger_period_us))
                      || (r_period_timer == '1);

    assign pulse_inc = r_pulse_timer + PULSE_W'(1);

    // Saturating wait count and its timeout test
    assign wait_inc     = (r_wait_timer == '1) ? r_wait_timer : r_wait_timer + WAIT_BITS'(1);
    assign wait_expired = (WCMP_W'(wait_inc) > WCMP_W'(r_echo_timeout_us))
                       || (wait_inc == '1);

    // Width step with a running quotient and remainder of width * 17 / 1000
    assign rem_add = {1'b0, r_rem} + DIST_STEP;
    always_comb begin
        if (r_echo_width == '1) begin
            width_inc = r_echo_width;
            rem_inc   = r_rem;
            dist_inc  = r_dist;
        end else if (rem_add >= DIST_DIV) begin
            width_inc = r_echo_width + ECHO_W'(1);
            rem_inc   = DIST_REM_W'(rem_add - DIST_DIV);
            dist_inc  = r_dist + DIST_W'(1);
        end else begin
            width_inc = r_echo_width + ECHO_W'(1);
            rem_inc   = rem_add[DIST_REM_W-1:0];
            dist_inc  = r_dist;
        end
    end

    // Completion of an echo: a fall after a rise succeeds, a bare fall fails
    assign echo_done = !rising && falling;
    assign echo_ok   = !rising && r_echo_started && (width_inc != '0);

    // Next state and result for one tick
    always_comb begin
        n_phase        = r_phase;
        n_period_timer = (r_period_timer == '1) ? r_period_timer
                                                : r_period_timer + PERIOD_BITS'(1);
        n_pulse_timer  = r_pulse_timer;
        n_wait_timer   = r_wait_timer;
        n_echo_width   = r_echo_width;
        n_rem          = r_rem;
        n_dist         = r_dist;
        n_echo_started = r_echo_started;
        n_out_trig     = 1'b0;
        n_out_status   = ST_NONE;
        n_out_dist     = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (period_done) begin
                    n_phase        = PH_LEAD;
                    n_pulse_timer  = '0;
                    n_period_timer = '0;
                end
            end
            PH_LEAD: begin
                n_pulse_timer = pulse_inc;
                if (pulse_inc >= LEAD_TICKS) begin
                    n_phase       = PH_HIGH;
                    n_pulse_timer = '0;
                end
            end
            PH_HIGH: begin
                n_out_trig    = 1'b1;
                n_pulse_timer = pulse_inc;
                if (pulse_inc >= r_trigger_width_us || pulse_inc == '0) begin
                    n_phase        = PH_WAIT;
                    n_pulse_timer  = '0;
                    n_wait_timer   = '0;
                    n_echo_width   = '0;
                    n_rem          = '0;
                    n_dist         = '0;
                    n_echo_started = 1'b0;
                end
            end
            PH_WAIT: begin
                // Track the echo pulse
                if (rising) begin
                    n_echo_started = 1'b1;
                    n_echo_width   = '0;
                    n_rem          = '0;
                    n_dist         = '0;
                end else if (r_echo_started) begin
                    n_echo_width = width_inc;
                    n_rem        = rem_inc;
                    n_dist       = dist_inc;
                end
                // Completion first, then the timeout
                if (echo_done) begin
                    n_out_status   = echo_ok ? ST_OK : ST_FAIL;
                    n_out_dist     = echo_ok ? dist_inc : '0;
                    n_phase        = PH_IDLE;
                    n_echo_started = 1'b0;
                end else begin
                    n_wait_timer = wait_inc;
                    if (wait_expired) begin
                        n_out_status   = ST_FAIL;
                        n_phase        = PH_IDLE;
                        n_echo_started = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the sequencer on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_period_timer <= '0;
            r_pulse_timer  <= '0;
            r_wait_timer   <= '0;
            r_echo_width   <= '0;
            r_rem          <= '0;
            r_dist         <= '0;
            r_echo_started <= 1'b0;
            r_last_echo    <= 1'b0;
        end else if (in_fire) begin
            r_phase        <= n_phase;
            r_period_timer <= n_period_timer;
            r_pulse_timer  <= n_pulse_timer;
            r_wait_timer   <= n_wait_timer;
            r_echo_width   <= n_echo_width;
            r_rem          <= n_rem;
            r_dist         <= n_dist;
            r_echo_started <= n_echo_started;
            r_last_echo    <= i_echo_level;
        end
    end

    // Output valid: set on an accepted beat, drop when the held beat leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result payload until replaced
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_trig   <= n_out_trig;
            r_out_status <= n_out_status;
            r_out_dist   <= n_out_dist;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_trig_level  = r_out_trig;
    assign o_status      = r_out_status;
    assign o_distance_cm = r_out_dist;

    // Checks
    `UER_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, 1'b1, r_rem < DIST_DIV[DIST_REM_W-1:0])
    `UER_ASSERT_IMP(a_dist_only_ok, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_distance_cm == '0)
    `UER_ASSERT_NXT(a_high_drives_trig, i_clk, i_rst_n, in_fire && (r_phase == PH_HIGH), o_trig_level && o_out_valid)
    `UER_ASSERT_NXT(a_result_to_idle, i_clk, i_rst_n, in_fire && (n_out_status != ST_NONE), r_phase == PH_IDLE)
    `UER_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)

endmodule
